/* rtl/core/lirs_pkg.sv */
`default_nettype none

package lirs_pkg;

  // out_channel width and the channel_count register width
  localparam int CHAN_BITS      = 3;
  localparam int COUNT_BITS     = 4;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_RATIO    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 1'b1;

  localparam logic [COUNT_BITS-1:0] CHANNEL_COUNT_RESET = 4'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_EMIT_RD,
    S_EMIT_MUL,
    S_EMIT_OUT
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/linear_interp_resampler.sv */
`default_nettype none

// Linear-interpolation sample rate converter for interleaved audio. Samples
// enter channel 0 first; per channel the previous and current frame are held
// as one entry {prev, cur} of a single-port-write, registered-read frame
// memory. Each accepted sample first reads its entry, then writes back
// {old cur, new sample}. When the sample completes a frame (and a frame is
// already held) the block emits every output frame whose phase lies below
// 1.0: each result is a memory read, a multiply and an add into the output
// register, and waits while the output register is held by stall. The input
// is stalled while a sample is stored and while its results are emitted.
// Writing step_ratio (index 0, unsigned Q4.FRAC_BITS, clamped to at least
// 0.125) or channel_count (index 1, 0 acts as 1, above MAX_CHANNELS acts as
// MAX_CHANNELS) clears the phase and history; the first complete frame after
// that produces nothing.
module linear_interp_resampler
  import lirs_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0]         cfg_index,
  input  wire logic [((FRAC_BITS + 4) > COUNT_BITS ? (FRAC_BITS + 4) : COUNT_BITS)-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_sample,
  output logic [CHAN_BITS-1:0]                   out_channel,
  output logic                                   last_of_run
);

  localparam int STEP_BITS  = FRAC_BITS + 4;
  localparam int PHASE_BITS = FRAC_BITS + 5;
  localparam int ADDR_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DEPTH      = 1 << ADDR_BITS;
  localparam int PROD_BITS  = SAMPLE_BITS + FRAC_BITS + 2;

  localparam logic [STEP_BITS-1:0]  STEP_RESET = STEP_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0]  STEP_MIN   = STEP_BITS'(1) << (FRAC_BITS - 3);
  localparam logic [PHASE_BITS-1:0] PHASE_ONE  = PHASE_BITS'(1) << FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] MAX_COUNT  = COUNT_BITS'(MAX_CHANNELS);

  state_t state, state_next;

  logic [STEP_BITS-1:0]   step_ratio;
  logic [COUNT_BITS-1:0]  channel_count;
  logic [PHASE_BITS-1:0]  phase, phase_next;
  logic [CHAN_BITS-1:0]   chpos, chpos_next;
  logic                   have_prev, have_prev_next;
  logic [CHAN_BITS-1:0]   emit_ch, emit_ch_next;
  logic [CHAN_BITS-1:0]   cur_ch;
  logic [SAMPLE_BITS-1:0] sample_hold;

  // {previous, current} per channel
  logic [2*SAMPLE_BITS-1:0] frame_mem [DEPTH];
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic [2*SAMPLE_BITS-1:0] mem_wdata;
  logic [ADDR_BITS-1:0]     mem_raddr;
  logic [ADDR_BITS-1:0]     mem_waddr;
  logic                     mem_we;

  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SAMPLE_BITS-1:0] prev_hold;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_BITS-1:0]   prod_shifted;

  logic [COUNT_BITS-1:0] nch;
  logic [STEP_BITS-1:0]  step_eff;
  logic [PHASE_BITS-1:0] phase_sum;
  logic [CHAN_BITS-1:0]  ch_sel;
  logic                  in_xfer;
  logic                  out_free;
  logic                  load_prod;
  logic                  load_out;
  logic                  last_next;

  always_comb begin
    if (channel_count == '0) begin
      nch = COUNT_BITS'(1);
    end else if (channel_count > MAX_COUNT) begin
      nch = MAX_COUNT;
    end else begin
      nch = channel_count;
    end
  end

  assign step_eff  = (step_ratio < STEP_MIN) ? STEP_MIN : step_ratio;
  assign phase_sum = phase + PHASE_BITS'(step_eff);
  assign ch_sel    = ({1'b0, chpos} >= nch) ? '0 : chpos;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    chpos_next     = chpos;
    have_prev_next = have_prev;
    emit_ch_next   = emit_ch;
    mem_raddr      = ch_sel[ADDR_BITS-1:0];
    mem_waddr      = cur_ch[ADDR_BITS-1:0];
    mem_wdata      = {rd_data[SAMPLE_BITS-1:0], sample_hold};
    mem_we         = 1'b0;
    load_prod      = 1'b0;
    load_out       = 1'b0;
    last_next      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        mem_we = 1'b1;
        if (({1'b0, cur_ch} + COUNT_BITS'(1)) < nch) begin
          chpos_next = cur_ch + CHAN_BITS'(1);
          state_next = S_IDLE;
        end else begin
          chpos_next = '0;
          if (!have_prev) begin
            have_prev_next = 1'b1;
            state_next     = S_IDLE;
          end else if (phase >= PHASE_ONE) begin
            // downsampling: this frame yields nothing
            phase_next = phase - PHASE_ONE;
            state_next = S_IDLE;
          end else begin
            emit_ch_next = '0;
            state_next   = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        mem_raddr  = emit_ch[ADDR_BITS-1:0];
        state_next = S_EMIT_MUL;
      end
      S_EMIT_MUL: begin
        load_prod  = 1'b1;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (({1'b0, emit_ch} + COUNT_BITS'(1)) == nch) begin
            emit_ch_next = '0;
            if (phase_sum < PHASE_ONE) begin
              phase_next = phase_sum;
              state_next = S_EMIT_RD;
            end else begin
              last_next  = 1'b1;
              phase_next = phase_sum - PHASE_ONE;
              state_next = S_IDLE;
            end
          end else begin
            emit_ch_next = emit_ch + CHAN_BITS'(1);
            state_next   = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_write) begin
      chpos_next     = '0;
      phase_next     = '0;
      have_prev_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= STEP_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
      phase         <= '0;
      chpos         <= '0;
      have_prev     <= 1'b0;
      emit_ch       <= '0;
    end else begin
      phase     <= phase_next;
      chpos     <= chpos_next;
      have_prev <= have_prev_next;
      emit_ch   <= emit_ch_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_STEP_RATIO:    step_ratio    <= cfg_data[STEP_BITS-1:0];
          REG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= frame_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_hold <= in_sample;
      cur_ch      <= ch_sel;
    end
  end

  // (cur - prev) * phase, with diff holding prev; phase is below 1.0 here so only its fraction bits matter
  assign diff = $signed({rd_data[2*SAMPLE_BITS-1], rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]});

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod      <= PROD_BITS'($signed({rd_data[SAMPLE_BITS-1], rd_data[SAMPLE_BITS-1:0]}) - diff)
                   * PROD_BITS'($signed({1'b0, phase[FRAC_BITS-1:0]}));
      prev_hold <= $signed(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    end
  end

  assign prod_shifted = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample  <= prev_hold + prod_shifted[SAMPLE_BITS-1:0];
      out_channel <= emit_ch;
      last_of_run <= last_next;
    end
  end

  a_emit_phase_below_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD || state == S_EMIT_MUL || state == S_EMIT_OUT) |->
      (phase < PHASE_ONE))
    else $error("emitting with phase at or above 1.0");

  a_chpos_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, chpos} < nch))
    else $error("channel position beyond channel count");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_OUT && out_free) |=> out_valid)
    else $error("result not presented after output load");

endmodule

`default_nettype wire

/* verif/linear_interp_resampler_checker.sv */
module linear_interp_resampler_checker
  import lirs_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16,
  parameter int CFG_BITS    = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_sample,
  input  logic [CHAN_BITS-1:0]          out_channel,
  input  logic                          last_of_run,
  output int                            sample_errors,
  output int                            outputs_owed
);

  localparam int MAX_CH     = 8;
  localparam int STEP_BITS  = FRAC_BITS + 4;
  localparam int PHASE_ONE  = 1 << FRAC_BITS;
  localparam int STEP_MIN   = 1 << (FRAC_BITS - 3);
  localparam int STEP_RESET = PHASE_ONE;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CHAN_BITS-1:0]          chan;
    logic                          last;
  } interp_word_t;

  interp_word_t                  expected_samples[$];

  logic signed [SAMPLE_BITS-1:0] prev_frame[MAX_CH];
  logic signed [SAMPLE_BITS-1:0] cur_frame[MAX_CH];
  int                            chan_pos;
  int                            phase_acc;
  logic                          primed;
  logic [STEP_BITS-1:0]          step_reg;
  logic [COUNT_BITS-1:0]         count_reg;

  task automatic clear_progress();
    chan_pos  = 0;
    phase_acc = 0;
    primed    = 1'b0;
  endtask

  // Store one sample; on a completed frame queue every interpolated output frame.
  task automatic interpolate_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int           nch;
    int           ch;
    int           stp;
    longint       diff;
    longint       val;
    interp_word_t w;
    interp_word_t run_q[$];
    nch = (count_reg == 0) ? 1 : (count_reg > MAX_CH) ? MAX_CH : int'(count_reg);
    ch  = (chan_pos >= nch) ? 0 : chan_pos;
    prev_frame[ch] = cur_frame[ch];
    cur_frame[ch]  = s;
    if (ch + 1 < nch) begin
      chan_pos = ch + 1;
      return;
    end
    chan_pos = 0;
    if (!primed) begin
      primed = 1'b1;
      return;
    end
    stp = (step_reg < STEP_MIN) ? STEP_MIN : int'(step_reg);
    while (phase_acc < PHASE_ONE) begin
      for (int c = 0; c < nch; c++) begin
        diff     = longint'(cur_frame[c]) - longint'(prev_frame[c]);
        // arithmetic shift of a signed product rounds toward minus infinity
        val      = longint'(prev_frame[c]) + ((diff * longint'(phase_acc)) >>> FRAC_BITS);
        w.sample = val[SAMPLE_BITS-1:0];
        w.chan   = c[CHAN_BITS-1:0];
        w.last   = 1'b0;
        run_q.push_back(w);
      end
      phase_acc += stp;
    end
    phase_acc -= PHASE_ONE;
    foreach (run_q[i]) begin
      w      = run_q[i];
      w.last = (i == run_q.size() - 1);
      expected_samples.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_samples.delete();
      for (int i = 0; i < MAX_CH; i++) begin
        prev_frame[i] = '0;
        cur_frame[i]  = '0;
      end
      clear_progress();
      step_reg      = STEP_BITS'(STEP_RESET);
      count_reg     = CHANNEL_COUNT_RESET;
      sample_errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          sample_errors++;
          $display("%0t: unexpected transfer: got sample %0d ch %0d last %0b",
                   $time, out_sample, out_channel, last_of_run);
        end else begin
          if (out_sample !== expected_samples[0].sample ||
              out_channel !== expected_samples[0].chan ||
              last_of_run !== expected_samples[0].last) begin
            sample_errors++;
            $display("%0t: mismatch: expected sample %0d ch %0d last %0b, got %0d ch %0d last %0b",
                     $time, expected_samples[0].sample, expected_samples[0].chan,
                     expected_samples[0].last, out_sample, out_channel, last_of_run);
          end
          void'(expected_samples.pop_front());
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_STEP_RATIO) begin
          step_reg = cfg_data[STEP_BITS-1:0];
          clear_progress();
        end else if (cfg_index == REG_CHANNEL_COUNT) begin
          count_reg = cfg_data[COUNT_BITS-1:0];
          clear_progress();
        end
      end
      if (in_valid && !in_stall)
        interpolate_sample(in_sample);
    end
    outputs_owed = expected_samples.size();
  end

endmodule

/* verif/linear_interp_resampler_tb.sv */
module linear_interp_resampler_tb;
  import lirs_pkg::*;

  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_BITS     = 20;
  localparam int RANDOM_ITEMS = 350;
  localparam int IDLE_GAP     = 12;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 3000000;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

  localparam logic [CFG_BITS-1:0] STEP_ZERO   = 20'd0;
  localparam logic [CFG_BITS-1:0] STEP_LOWEST = 20'd8192;
  localparam logic [CFG_BITS-1:0] STEP_UNITY  = 20'd65536;
  localparam logic [CFG_BITS-1:0] STEP_TOP    = 20'd524288;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [CFG_BITS-1:0]           cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic [CHAN_BITS-1:0]          out_channel;
  logic                          last_of_run;

  int sample_errors;
  int outputs_owed;
  int in_count;
  bit in_calm;

  linear_interp_resampler DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_channel(out_channel),
    .last_of_run(last_of_run)
  );

  linear_interp_resampler_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .CFG_BITS   (CFG_BITS)
  ) out_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .out_channel  (out_channel),
    .last_of_run  (last_of_run),
    .sample_errors(sample_errors),
    .outputs_owed (outputs_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random hold-off before each transfer, with calm stretches.
  initial begin
    int gap;
    int out_count;
    bit out_calm;
    out_stall = 1'b0;
    out_count = 0;
    out_calm  = 1'b0;
    @(negedge clk);
    forever begin
      if (out_count % 32 == 0)
        out_calm = ($urandom_range(0, 3) == 0);
      out_count++;
      gap = out_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // One write cycle, then cfg_write is dropped so back-to-back writes stay apart.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_channels(input logic [COUNT_BITS-1:0] cnt);
    logic [CFG_BITS-1:0] data;
    data = CFG_BITS'($urandom);
    data[COUNT_BITS-1:0] = cnt;
    write_reg(REG_CHANNEL_COUNT, data);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    if (in_count % 32 == 0)
      in_calm = ($urandom_range(0, 3) == 0);
    in_count++;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (outputs_owed != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 7))
      0: s = SAMPLE_MAX;
      1: s = SAMPLE_MIN;
      2: begin
        s = SAMPLE_BITS'($urandom_range(0, 32));
        s = s - 24'sd16;
      end
      default: s = SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  initial begin
    int                    random_sent;
    int                    n;
    logic [CFG_BITS-1:0]   stp;
    logic [COUNT_BITS-1:0] cnt;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = REG_STEP_RATIO;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_sample   = '0;
    in_count    = 0;
    in_calm     = 1'b0;
    random_sent = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: unity step, two channels, full-scale swings
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(24'sd0);
    send_sample(-24'sd1);
    in_valid <= 1'b0;
    wait_drained();

    // zero step clamps to 1/8, zero channels acts as one
    write_reg(REG_STEP_RATIO, STEP_ZERO);
    write_channels(4'd0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    in_valid <= 1'b0;
    wait_drained();

    // step 8.0: most frames emit nothing
    write_reg(REG_STEP_RATIO, STEP_TOP);
    write_channels(4'd1);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(24'sd12345);
    send_sample(-24'sd1);
    send_sample(SAMPLE_MAX);
    in_valid <= 1'b0;

    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:       stp = CFG_BITS'($urandom_range(0, 8191));
        1:       stp = STEP_LOWEST;
        2:       stp = STEP_TOP;
        3:       stp = STEP_UNITY;
        default: stp = CFG_BITS'($urandom_range(8192, 524288));
      endcase
      case ($urandom_range(0, 7))
        0:       cnt = 4'd0;
        1:       cnt = 4'd15;
        2:       cnt = 4'd8;
        3:       cnt = 4'd1;
        default: cnt = COUNT_BITS'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_STEP_RATIO, stp);
        1: write_channels(cnt);
        2: begin
          write_reg(REG_STEP_RATIO, stp);
          write_channels(cnt);
        end
        default: begin
          write_channels(cnt);
          write_reg(REG_STEP_RATIO, stp);
        end
      endcase
      n = $urandom_range(8, 48);
      repeat (n) begin
        send_sample(draw_sample());
        random_sent++;
      end
      in_valid <= 1'b0;
    end

    while (outputs_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sample_errors == 0 && outputs_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
